// File: rtl/sic_pkg.sv
// Shared types and constants for the slope illumination cosine pipeline.
// No dependencies; used by sic_horner_step and slope_illumination_cosine_unit.

package sic_pkg;

	// angle to phase scale factors (2^32 = one turn)
	localparam logic [24:0] AZ_PHASE_K = 25'd23860929;
	localparam logic [24:0] EX_PHASE_K = 25'd21361415;

	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [29:0] HALF_Q30 = 30'h2000_0000;
	localparam logic [15:0] ONE_Q15  = 16'h8000;

	localparam logic signed [32:0] COS_MAX  = 33'sh0_4000_0000;
	localparam logic signed [63:0] ONE_Q60  = 64'sh1000_0000_0000_0000;
	localparam logic signed [63:0] RND_Q45  = 64'sh0000_1000_0000_0000;

	// Taylor series divisors, innermost first
	localparam int HORNER_STEPS = 5;
	typedef logic [$clog2(HORNER_STEPS)-1:0] step_idx_t;

	// floor(q/d) = (q * m) >> s for any 32-bit q, with m = floor(2^s/d) + 1,
	// s = 32 + ceil(log2(d)), so m stays within 33 bits
	localparam logic [32:0] MAGIC_132 = 33'((64'd1 << 40) / 132 + 1);
	localparam logic [32:0] MAGIC_90  = 33'((64'd1 << 39) / 90 + 1);
	localparam logic [32:0] MAGIC_56  = 33'((64'd1 << 38) / 56 + 1);
	localparam logic [32:0] MAGIC_30  = 33'((64'd1 << 37) / 30 + 1);
	localparam logic [32:0] MAGIC_12  = 33'((64'd1 << 36) / 12 + 1);

	typedef struct packed {
		logic               masked;
		logic               neg;
		logic signed [31:0] czcs;
		logic signed [31:0] szss;
	} side_t;

	typedef struct packed {
		logic [31:0] x2;
		logic [30:0] t;
		side_t       side;
	} horner_t;

	function automatic logic [32:0] horner_magic(input step_idx_t idx);
		logic [32:0] m;
		unique case (idx)
			step_idx_t'(0): m = MAGIC_132;
			step_idx_t'(1): m = MAGIC_90;
			step_idx_t'(2): m = MAGIC_56;
			step_idx_t'(3): m = MAGIC_30;
			step_idx_t'(4): m = MAGIC_12;
			default:        m = MAGIC_12;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] horner_shift(input step_idx_t idx);
		logic [5:0] s;
		unique case (idx)
			step_idx_t'(0): s = 6'd40;
			step_idx_t'(1): s = 6'd39;
			step_idx_t'(2): s = 6'd38;
			step_idx_t'(3): s = 6'd37;
			step_idx_t'(4): s = 6'd36;
			default:        s = 6'd36;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/sic_horner_step.sv
// One nested-evaluation step of the cosine series: t' = 1 - floor(x2*t)/d.
// Two pipeline stages (multiply, reciprocal multiply). Depends on sic_pkg.

module sic_horner_step (
	input  logic              clk,
	input  logic              arst_n,
	input  sic_pkg::step_idx_t div_idx,
	input  logic              up_valid,
	input  sic_pkg::horner_t  up_data,
	output logic              up_take,
	output logic              dn_valid,
	output sic_pkg::horner_t  dn_data,
	input  logic              dn_take
);
	import sic_pkg::*;

	logic        v_s1, v_s2;
	logic        en_s1, en_s2;
	logic [31:0] x2_s1, x2_s2;
	side_t       side_s1, side_s2;
	logic [31:0] q_s1;
	logic [64:0] mp_s2;

	logic [62:0] prod_a;
	logic [64:0] mp;
	logic [31:0] p;
	logic [30:0] t_next;

	assign en_s2   = !v_s2 || dn_take;
	assign en_s1   = !v_s1 || en_s2;
	assign up_take = en_s1;

	always_comb begin
		prod_a = 63'(up_data.x2) * 63'(up_data.t);
		mp     = 65'(q_s1) * 65'(horner_magic(div_idx));
		p      = 32'(mp_s2 >> horner_shift(div_idx));
		t_next = (p >= 32'(ONE_Q30)) ? '0 : 31'(32'(ONE_Q30) - p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			q_s1    <= prod_a[61:30];
			x2_s1   <= up_data.x2;
			side_s1 <= up_data.side;
		end
		if (en_s2) begin
			mp_s2   <= mp;
			x2_s2   <= x2_s1;
			side_s2 <= side_s1;
		end
	end

	assign dn_valid     = v_s2;
	assign dn_data.x2   = x2_s2;
	assign dn_data.t    = t_next;
	assign dn_data.side = side_s2;

endmodule

// File: rtl/slope_illumination_cosine_unit.sv
// Top level: cosine of the local solar illumination angle on a sloped pixel.
// Depends on sic_pkg and sic_horner_step.
//
// Usage:
//  - Pixel channel (pix_valid / pix_stall): one item per pixel, carrying the
//    zenith and slope cos/sin (Q1.15), sun azimuth (1/128 deg), slope exposure
//    (Q3.13 rad) and the mask bit. Accepted when pix_valid and !pix_stall.
//  - Result channel (res_valid / res_stall): one item per pixel, illum_cos in
//    Q1.15 clamped to [0, 1.0], 0 for a masked pixel. Taken when res_valid
//    and !res_stall. Items leave in the order they came in.
//  - Config channel (cfg_valid / cfg_ready): writes use_mask; always ready.
//    Write it only while no pixel is in flight.
// Pipeline: 19 register stages (6 front: phase, fold, x^2; 5 series steps of 2;
//  3 back). Throughput: one pixel per clock unless held by res_stall; every stage
//  is a fully pipelined unit.
// Reset clears all valid bits and use_mask; the pipeline comes up empty.
// Stall: each stage holds while the one after it is full and held, so
//  bubbles are squeezed out; pix_stall rises only once every stage is full
//  and res_stall is high.

module slope_illumination_cosine_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               use_mask,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  logic signed [15:0] cos_zenith,
	input  logic signed [15:0] sin_zenith,
	input  logic signed [15:0] cos_slope,
	input  logic signed [15:0] sin_slope,
	input  logic signed [15:0] sun_azimuth,
	input  logic signed [15:0] slope_exposure,
	input  logic               mask_on,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [15:0]        illum_cos
);
	import sic_pkg::*;

	logic use_mask_q;

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;

	// stage payloads
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	side_t              side_s7, side_s8;
	logic signed [40:0] paz_s1, pex_s1;
	logic [31:0]        d_s2;
	logic [30:0]        ar_s3;
	logic [62:0]        xp_s4;
	logic [61:0]        xx_s5;
	logic [31:0]        x2_s6;
	logic [31:0]        q_s7;
	logic signed [63:0] prod_s8;
	logic [15:0]        illum_s9;

	// series step chain
	horner_t hd [HORNER_STEPS+1];
	logic    hv [HORNER_STEPS+1];
	logic    hen[HORNER_STEPS+1];

	// combinational stage logic
	logic signed [40:0] az_ext, ex_ext, paz, pex, saz, sex;
	logic [31:0]        phase_az, phase_ex;
	logic [31:0]        fold_chk, r, rabs;
	logic               fold;
	side_t              side_n3;
	logic [62:0]        xp, xr, fp;
	logic [61:0]        xx, xxr;
	logic [30:0]        x;
	logic [30:0]        half;
	logic signed [32:0] c_raw, c_cl;
	logic signed [31:0] cosd;
	logic signed [63:0] prod, mu, mu_r;
	logic [15:0]        res;
	side_t              side_n1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_mask_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			use_mask_q <= use_mask;
		end
	end

	// enable chain: a stage loads when it is empty or its item moves on
	assign en_s9 = !v_s9 || !res_stall;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign hen[HORNER_STEPS] = en_s7;
	assign en_s6 = !v_s6 || hen[0];
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pix_stall = !en_s1;

	always_comb begin
		// s1: angles to 32-bit phases, trig products, mask
		az_ext = 41'(sun_azimuth);
		ex_ext = 41'(slope_exposure);
		paz    = az_ext * $signed(41'(AZ_PHASE_K));
		pex    = ex_ext * $signed(41'(EX_PHASE_K));
		side_n1.masked = use_mask_q && !mask_on;
		side_n1.neg    = 1'b0;
		side_n1.czcs   = 32'(cos_zenith) * 32'(cos_slope);
		side_n1.szss   = 32'(sin_zenith) * 32'(sin_slope);

		// s2: rounded phases, difference mod 2^32
		saz      = paz_s1 + 41'sd128;
		sex      = pex_s1 + 41'sd128;
		phase_az = saz[39:8];
		phase_ex = sex[39:8];

		// s3: fold the half turn around pi onto the other side, note the sign
		fold_chk = d_s2 + 32'h4000_0000;
		fold     = fold_chk[31];
		r        = fold ? {~d_s2[31], d_s2[30:0]} : d_s2;
		rabs     = r[31] ? (~r + 32'd1) : r;
		side_n3     = side_s2;
		side_n3.neg = fold;

		// s4: phase to radians, Q61
		xp = 63'(ar_s3) * 63'(PI_Q30);

		// s5: x and its square
		xr = xp_s4 + 63'(ONE_Q30);
		x  = xr[61:31];
		xx = 62'(x) * 62'(x);

		// s6: x^2 rounded to Q30
		xxr = xx_s5 + 62'(HALF_Q30);

		// s7: last series term
		fp = 63'(hd[HORNER_STEPS].x2) * 63'(hd[HORNER_STEPS].t);

		// s8: cosine, clamped and signed, times sinZ*sinS
		half  = q_s7[31:1];
		c_raw = $signed(33'(ONE_Q30)) - $signed({2'b00, half});
		if (c_raw > COS_MAX)
			c_cl = COS_MAX;
		else if (c_raw < -COS_MAX)
			c_cl = -COS_MAX;
		else
			c_cl = c_raw;
		cosd = side_s7.neg ? 32'(-c_cl) : 32'(c_cl);
		prod = 64'(side_s7.szss) * 64'(cosd);

		// s9: mu in Q60, clamp and round to Q15
		mu   = (64'(side_s8.czcs) <<< 30) + prod_s8;
		mu_r = mu + RND_Q45;
		if (side_s8.masked || mu <= 64'sd0)
			res = '0;
		else if (mu >= ONE_Q60)
			res = ONE_Q15;
		else
			res = mu_r[60:45];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= hv[HORNER_STEPS];
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			paz_s1  <= paz;
			pex_s1  <= pex;
			side_s1 <= side_n1;
		end
		if (en_s2) begin
			d_s2    <= phase_az - phase_ex;
			side_s2 <= side_s1;
		end
		if (en_s3) begin
			ar_s3   <= rabs[30:0];
			side_s3 <= side_n3;
		end
		if (en_s4) begin
			xp_s4   <= xp;
			side_s4 <= side_s3;
		end
		if (en_s5) begin
			xx_s5   <= xx;
			side_s5 <= side_s4;
		end
		if (en_s6) begin
			x2_s6   <= xxr[61:30];
			side_s6 <= side_s5;
		end
		if (en_s7) begin
			q_s7    <= fp[61:30];
			side_s7 <= hd[HORNER_STEPS].side;
		end
		if (en_s8) begin
			prod_s8 <= prod;
			side_s8 <= side_s7;
		end
		if (en_s9) begin
			illum_s9 <= res;
		end
	end

	// series: innermost term starts from t = 1.0
	assign hv[0]      = v_s6;
	assign hd[0].x2   = x2_s6;
	assign hd[0].t    = ONE_Q30;
	assign hd[0].side = side_s6;

	for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
		sic_horner_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.div_idx  (step_idx_t'(i)),
			.up_valid (hv[i]),
			.up_data  (hd[i]),
			.up_take  (hen[i]),
			.dn_valid (hv[i+1]),
			.dn_data  (hd[i+1]),
			.dn_take  (hen[i+1])
		);
	end

	assign res_valid = v_s9;
	assign illum_cos = illum_s9;

	// stall reaches the pixel side only when the result side is holding
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (res_valid && res_stall))
		else $error("pixel stall without a held result");

	// a masked pixel leaves as zero
	a_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && en_s9 && side_s8.masked) |=> (illum_s9 == '0))
		else $error("masked pixel gave a nonzero result");

	// result never exceeds 1.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (illum_cos <= ONE_Q15))
		else $error("illumination cosine above 1.0");

endmodule
